### sv/vnt_pkg.sv
// ----------------------------------------------------------------------------
// vnt_pkg
// Shared constants, codes and stage payload types of the terrain classifier.
// ----------------------------------------------------------------------------
package vnt_pkg;

    localparam int WORLD_HEIGHT = 256;
    localparam int CELL_SHIFT   = 4;
    localparam int SEED_W       = 32;
    localparam int HEIGHT_CFG_W = 12;
    localparam int COORD_W      = 32;
    localparam int Y_W          = 16;
    localparam int FRAC_W       = CELL_SHIFT;
    localparam int NOISE_W      = 24;
    localparam int ROW_W        = 28;
    localparam int BLEND_W      = 32;
    localparam int SURF_W       = 14;
    localparam int KIND_W       = 3;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_DATA_W    = 80;
    localparam int OUT_DATA_W   = 24;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    localparam logic [CFG_ADDR_W-1:0] CFG_SEED      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMPLITUDE = 2'd2;

    localparam logic [HEIGHT_CFG_W-1:0] BASE_RESET      = 12'd64;
    localparam logic [HEIGHT_CFG_W-1:0] AMPLITUDE_RESET = 12'd16;

    localparam logic [KIND_W-1:0] KIND_AIR     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BEDROCK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GRASS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIRT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STONE   = 3'd4;

    // Corner order: 0 (x0,z0), 1 (x1,z0), 2 (x0,z1), 3 (x1,z1).
    typedef struct packed {
        logic [3:0][31:0]       mix;
        logic [FRAC_W-1:0]      fx;
        logic [FRAC_W-1:0]      fz;
        logic signed [Y_W-1:0]  wy;
    } t_hash_out;

    typedef struct packed {
        logic                     neg;
        logic [HEIGHT_CFG_W-1:0]  q;
        logic signed [Y_W-1:0]    wy;
    } t_blend_out;

endpackage

### sv/vnt_hash.sv
// ----------------------------------------------------------------------------
// vnt_hash
// Two pipeline stages that find the lattice cell and mix the four corner hashes.
// ----------------------------------------------------------------------------
module vnt_hash (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [vnt_pkg::COORD_W-1:0]    i_x,
    input  logic signed [vnt_pkg::Y_W-1:0]        i_y,
    input  logic signed [vnt_pkg::COORD_W-1:0]    i_z,
    input  logic [vnt_pkg::SEED_W-1:0]            i_seed,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output vnt_pkg::t_hash_out                    o_data
);

    logic                            r_a_v;
    logic [1:0][31:0]                r_a_px;
    logic [1:0][31:0]                r_a_pz;
    logic [vnt_pkg::FRAC_W-1:0]      r_a_fx;
    logic [vnt_pkg::FRAC_W-1:0]      r_a_fz;
    logic signed [vnt_pkg::Y_W-1:0]  r_a_wy;
    logic                            r_b_v;
    vnt_pkg::t_hash_out              r_b_data;

    logic             w_en_a;
    logic             w_en_b;
    logic [31:0]      w_cx0;
    logic [31:0]      w_cx1;
    logic [31:0]      w_cz0;
    logic [31:0]      w_cz1;
    logic [1:0][31:0] n_px;
    logic [1:0][31:0] n_pz;
    logic [3:0][31:0] w_h;
    logic [3:0][31:0] w_hs;
    logic [3:0][31:0] n_mix;

    assign w_en_b  = !r_b_v || i_ready;
    assign w_en_a  = !r_a_v || w_en_b;
    assign o_ready = w_en_a;

    assign w_cx0 = 32'(i_x >>> vnt_pkg::CELL_SHIFT);
    assign w_cz0 = 32'(i_z >>> vnt_pkg::CELL_SHIFT);
    assign w_cx1 = w_cx0 + 32'd1;
    assign w_cz1 = w_cz0 + 32'd1;

    always_comb begin
        n_px[0] = w_cx0 * vnt_pkg::HASH_MUL_X;
        n_px[1] = w_cx1 * vnt_pkg::HASH_MUL_X;
        n_pz[0] = w_cz0 * vnt_pkg::HASH_MUL_Z;
        n_pz[1] = w_cz1 * vnt_pkg::HASH_MUL_Z;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_h[k]   = i_seed ^ r_a_px[k % 2] ^ r_a_pz[k / 2];
            w_hs[k]  = w_h[k] ^ (w_h[k] >> 13);
            n_mix[k] = w_hs[k] * vnt_pkg::HASH_MUL_MIX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_v <= i_valid;
            end
            if (w_en_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_px <= n_px;
            r_a_pz <= n_pz;
            r_a_fx <= i_x[vnt_pkg::FRAC_W-1:0];
            r_a_fz <= i_z[vnt_pkg::FRAC_W-1:0];
            r_a_wy <= i_y;
        end
        if (w_en_b) begin
            r_b_data.mix <= n_mix;
            r_b_data.fx  <= r_a_fx;
            r_b_data.fz  <= r_a_fz;
            r_b_data.wy  <= r_a_wy;
        end
    end

    assign o_valid = r_b_v;
    assign o_data  = r_b_data;

endmodule

### sv/vnt_blend.sv
// ----------------------------------------------------------------------------
// vnt_blend
// Three pipeline stages: bilinear blend of the corner noise and height offset.
// ----------------------------------------------------------------------------
module vnt_blend (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  vnt_pkg::t_hash_out                     i_data,
    input  logic [vnt_pkg::HEIGHT_CFG_W-1:0]       i_amplitude,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output vnt_pkg::t_blend_out                    o_data
);

    logic                            r_c_v;
    logic [vnt_pkg::ROW_W-1:0]       r_c_r0;
    logic [vnt_pkg::ROW_W-1:0]       r_c_r1;
    logic [vnt_pkg::FRAC_W-1:0]      r_c_fz;
    logic signed [vnt_pkg::Y_W-1:0]  r_c_wy;
    logic                            r_d_v;
    logic [vnt_pkg::BLEND_W-1:0]     r_d_mag;
    logic                            r_d_neg;
    logic signed [vnt_pkg::Y_W-1:0]  r_d_wy;
    logic                            r_e_v;
    vnt_pkg::t_blend_out             r_e_data;

    logic                                w_en_c;
    logic                                w_en_d;
    logic                                w_en_e;
    logic [3:0][vnt_pkg::NOISE_W-1:0]    w_v;
    logic [vnt_pkg::FRAC_W:0]            w_wx0;
    logic [vnt_pkg::FRAC_W:0]            w_wz0;
    logic [vnt_pkg::ROW_W:0]             w_row0;
    logic [vnt_pkg::ROW_W:0]             w_row1;
    logic [vnt_pkg::BLEND_W:0]           w_sum;
    logic [vnt_pkg::BLEND_W-1:0]         w_n;
    logic                                n_neg;
    logic [vnt_pkg::BLEND_W-1:0]         n_mag;
    logic [43:0]                         w_prod;
    logic [44:0]                         w_round;

    assign w_en_e  = !r_e_v || i_ready;
    assign w_en_d  = !r_d_v || w_en_e;
    assign w_en_c  = !r_c_v || w_en_d;
    assign o_ready = w_en_c;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_v[k] = i_data.mix[k][vnt_pkg::NOISE_W-1:0]
                   ^ {8'd0, i_data.mix[k][31:16]};
        end
    end

    assign w_wx0  = 5'd16 - {1'b0, i_data.fx};
    assign w_row0 = 29'(w_v[0]) * 29'(w_wx0) + 29'(w_v[1]) * 29'({1'b0, i_data.fx});
    assign w_row1 = 29'(w_v[2]) * 29'(w_wx0) + 29'(w_v[3]) * 29'({1'b0, i_data.fx});

    assign w_wz0 = 5'd16 - {1'b0, r_c_fz};
    assign w_sum = 33'(r_c_r0) * 33'(w_wz0) + 33'(r_c_r1) * 33'({1'b0, r_c_fz});
    assign w_n   = w_sum[vnt_pkg::BLEND_W-1:0];
    assign n_neg = !w_n[31];
    assign n_mag = n_neg ? (32'h8000_0000 - w_n) : (w_n - 32'h8000_0000);

    assign w_prod  = r_d_mag * i_amplitude;
    assign w_round = 45'(w_prod) + 45'h0_4000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (w_en_c) begin
                r_c_v <= i_valid;
            end
            if (w_en_d) begin
                r_d_v <= r_c_v;
            end
            if (w_en_e) begin
                r_e_v <= r_d_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_r0 <= w_row0[vnt_pkg::ROW_W-1:0];
            r_c_r1 <= w_row1[vnt_pkg::ROW_W-1:0];
            r_c_fz <= i_data.fz;
            r_c_wy <= i_data.wy;
        end
        if (w_en_d) begin
            r_d_mag <= n_mag;
            r_d_neg <= n_neg;
            r_d_wy  <= r_c_wy;
        end
        if (w_en_e) begin
            r_e_data.neg <= r_d_neg;
            r_e_data.q   <= w_round[42:31];
            r_e_data.wy  <= r_d_wy;
        end
    end

    assign o_valid = r_e_v;
    assign o_data  = r_e_data;

endmodule

### sv/vnt_classify.sv
// ----------------------------------------------------------------------------
// vnt_classify
// Two pipeline stages: surface height, then block class and output register.
// ----------------------------------------------------------------------------
module vnt_classify (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  vnt_pkg::t_blend_out                   i_data,
    input  logic [vnt_pkg::HEIGHT_CFG_W-1:0]      i_base,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [vnt_pkg::KIND_W-1:0]            o_kind,
    output logic signed [vnt_pkg::SURF_W-1:0]     o_height
);

    localparam logic signed [16:0] WorldTop = 17'(vnt_pkg::WORLD_HEIGHT);

    logic                                r_f_v;
    logic signed [vnt_pkg::SURF_W-1:0]   r_f_h;
    logic signed [vnt_pkg::Y_W-1:0]      r_f_wy;
    logic                                r_g_v;
    logic [vnt_pkg::KIND_W-1:0]          r_g_kind;
    logic signed [vnt_pkg::SURF_W-1:0]   r_g_h;

    logic                                w_en_f;
    logic                                w_en_g;
    logic [vnt_pkg::SURF_W-1:0]          w_q;
    logic signed [vnt_pkg::SURF_W-1:0]   n_h;
    logic signed [16:0]                  w_y;
    logic signed [16:0]                  w_h;
    logic [vnt_pkg::KIND_W-1:0]          n_kind;

    assign w_en_g  = !r_g_v || i_ready;
    assign w_en_f  = !r_f_v || w_en_g;
    assign o_ready = w_en_f;

    assign w_q = {2'b00, i_data.q};
    assign n_h = $signed({2'b00, i_base} + (i_data.neg ? -w_q : w_q));

    assign w_y = {r_f_wy[vnt_pkg::Y_W-1], r_f_wy};
    assign w_h = {{3{r_f_h[vnt_pkg::SURF_W-1]}}, r_f_h};

    always_comb begin
        if (w_y < 17'sd0 || w_y >= WorldTop) begin
            n_kind = vnt_pkg::KIND_AIR;
        end else if (w_y == 17'sd0) begin
            n_kind = vnt_pkg::KIND_BEDROCK;
        end else if (w_y > w_h) begin
            n_kind = vnt_pkg::KIND_AIR;
        end else if (w_y == w_h) begin
            n_kind = vnt_pkg::KIND_GRASS;
        end else if (w_y >= w_h - 17'sd2) begin
            n_kind = vnt_pkg::KIND_DIRT;
        end else begin
            n_kind = vnt_pkg::KIND_STONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else begin
            if (w_en_f) begin
                r_f_v <= i_valid;
            end
            if (w_en_g) begin
                r_g_v <= r_f_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_f) begin
            r_f_h  <= n_h;
            r_f_wy <= i_data.wy;
        end
        if (w_en_g) begin
            r_g_kind <= n_kind;
            r_g_h    <= r_f_h;
        end
    end

    assign o_valid  = r_g_v;
    assign o_kind   = r_g_kind;
    assign o_height = r_g_h;

endmodule

### sv/value_noise_terrain_block_classifier_core.sv
// ----------------------------------------------------------------------------
// value_noise_terrain_block_classifier_core
// Classifies a world block as air, bedrock, grass, dirt or stone from 2D noise.
// ----------------------------------------------------------------------------
// The slave stream carries one coordinate request per beat and the master
// stream returns one result per request, in order. Seed, base height and
// amplitude must be written through the plain register port only while no
// request is in flight; the block itself does not enforce this.
// The datapath is a seven-stage pipeline: two stages hash the four lattice
// corners, three blend the noise and scale it to a height offset, and two
// form the surface height and the block class. One request is taken every
// cycle until a stalled receiver has filled every stage.
// Every stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled receiver first fills the empty stages and
// only then deasserts s_axis_tready. Nothing is dropped or repeated.
// Reset clears all valid bits and returns the registers to seed 0, base
// height 64 and amplitude 16.
// ----------------------------------------------------------------------------
module value_noise_terrain_block_classifier_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis_tdata: world_x [31:0], world_y [47:32], world_z [79:48]
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [vnt_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // m_axis_tdata: block_kind [2:0], surface_height [16:3], zero [23:17]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [vnt_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [vnt_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [vnt_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    logic [vnt_pkg::SEED_W-1:0]        r_seed;
    logic [vnt_pkg::HEIGHT_CFG_W-1:0]  r_base;
    logic [vnt_pkg::HEIGHT_CFG_W-1:0]  r_amplitude;

    logic                               w_hash_valid;
    logic                               w_hash_ready;
    vnt_pkg::t_hash_out                 w_hash_data;
    logic                               w_blend_valid;
    logic                               w_blend_ready;
    vnt_pkg::t_blend_out                w_blend_data;
    logic [vnt_pkg::KIND_W-1:0]         w_kind;
    logic signed [vnt_pkg::SURF_W-1:0]  w_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_base      <= vnt_pkg::BASE_RESET;
            r_amplitude <= vnt_pkg::AMPLITUDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vnt_pkg::CFG_SEED:      r_seed      <= i_cfg_wdata;
                vnt_pkg::CFG_BASE:      r_base      <= i_cfg_wdata[vnt_pkg::HEIGHT_CFG_W-1:0];
                vnt_pkg::CFG_AMPLITUDE: r_amplitude <= i_cfg_wdata[vnt_pkg::HEIGHT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vnt_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     ($signed(s_axis_tdata[31:0])),
        .i_y     ($signed(s_axis_tdata[47:32])),
        .i_z     ($signed(s_axis_tdata[79:48])),
        .i_seed  (r_seed),
        .o_valid (w_hash_valid),
        .i_ready (w_hash_ready),
        .o_data  (w_hash_data)
    );

    vnt_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_hash_valid),
        .o_ready     (w_hash_ready),
        .i_data      (w_hash_data),
        .i_amplitude (r_amplitude),
        .o_valid     (w_blend_valid),
        .i_ready     (w_blend_ready),
        .o_data      (w_blend_data)
    );

    vnt_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_blend_valid),
        .o_ready  (w_blend_ready),
        .i_data   (w_blend_data),
        .i_base   (r_base),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (w_kind),
        .o_height (w_height)
    );

    assign m_axis_tdata = {7'd0, w_height, w_kind};

endmodule

### sv/vnt_checker.sv
// ----------------------------------------------------------------------------
// vnt_checker
// Port-level checks of the terrain classifier, bound to its top level.
// ----------------------------------------------------------------------------
module vnt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [vnt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // Reset empties the pipeline on the next edge.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // With no result held, every stage can move, so s_axis_tready is high.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    a_kind_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == vnt_pkg::KIND_AIR
                        || m_axis_tdata[2:0] == vnt_pkg::KIND_BEDROCK
                        || m_axis_tdata[2:0] == vnt_pkg::KIND_GRASS
                        || m_axis_tdata[2:0] == vnt_pkg::KIND_DIRT
                        || m_axis_tdata[2:0] == vnt_pkg::KIND_STONE))
        else $error("block class out of range");

    a_pad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
        else $error("padding bits not zero");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind value_noise_terrain_block_classifier_core vnt_checker u_vnt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
